// ===== rtl/core/fractional_baud_divisor_search_assert.svh =====
// Assertion macros for the fractional baud divisor search block.
// Each use samples on clk and is held off while rst_n is low.
`ifndef FRACTIONAL_BAUD_DIVISOR_SEARCH_ASSERT_SVH
`define FRACTIONAL_BAUD_DIVISOR_SEARCH_ASSERT_SVH

// Same-cycle implication.
`define FBDS_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication.
`define FBDS_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== rtl/core/fbds_pkg.sv =====
`default_nettype none

package fbds_pkg;

  localparam int CLK_W   = 27;
  localparam int BPS_W   = 22;
  localparam int PORT_W  = 2;
  localparam int BASE_W  = BPS_W + 4;     // 16 * bps
  localparam int C1K_W   = 37;            // clk * 1000
  localparam int EST_W   = 16;
  localparam int PROD_W  = BASE_W + EST_W; // base * est, also holds base * trial
  localparam int DIV_W   = 43;            // clk * 2000 + den, and 2 * den
  localparam int FR_W    = 11;            // fractions in thousandths, below 2048
  localparam int MV_W    = 4;
  localparam int TAB_ENTRIES = 72;
  localparam int TAB_IW  = 7;

  localparam logic [CLK_W-1:0] CLK_RESET = 27'd25000000;
  localparam logic [FR_W-1:0]  FR_LOW    = 11'd1100;
  localparam logic [FR_W-1:0]  FR_HIGH   = 11'd1900;
  localparam logic [FR_W-1:0]  FR_STEP   = 11'd100;
  localparam logic [FR_W-1:0]  FR_START  = 11'd1500;
  localparam logic [MV_W-1:0]  FDR_OFF_MUL = 4'd1;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  typedef struct packed {
    logic [FR_W-1:0] milli;
    logic [MV_W-1:0] add;
    logic [MV_W-1:0] mul;
  } frac_entry_t;

  // Fraction table: 1 + add/mul in thousandths, ascending.
  function automatic frac_entry_t frac_entry(input logic [TAB_IW-1:0] idx);
    frac_entry_t e;
    case (idx)
      7'd0:  e = '{11'd1000, 4'd0, 4'd1};
      7'd1:  e = '{11'd1067, 4'd1, 4'd15};
      7'd2:  e = '{11'd1071, 4'd1, 4'd14};
      7'd3:  e = '{11'd1077, 4'd1, 4'd13};
      7'd4:  e = '{11'd1083, 4'd1, 4'd12};
      7'd5:  e = '{11'd1091, 4'd1, 4'd11};
      7'd6:  e = '{11'd1100, 4'd1, 4'd10};
      7'd7:  e = '{11'd1111, 4'd1, 4'd9};
      7'd8:  e = '{11'd1125, 4'd1, 4'd8};
      7'd9:  e = '{11'd1133, 4'd2, 4'd15};
      7'd10: e = '{11'd1143, 4'd1, 4'd7};
      7'd11: e = '{11'd1154, 4'd2, 4'd13};
      7'd12: e = '{11'd1167, 4'd1, 4'd6};
      7'd13: e = '{11'd1182, 4'd2, 4'd11};
      7'd14: e = '{11'd1200, 4'd1, 4'd5};
      7'd15: e = '{11'd1214, 4'd3, 4'd14};
      7'd16: e = '{11'd1222, 4'd2, 4'd9};
      7'd17: e = '{11'd1231, 4'd3, 4'd13};
      7'd18: e = '{11'd1250, 4'd1, 4'd4};
      7'd19: e = '{11'd1267, 4'd4, 4'd15};
      7'd20: e = '{11'd1273, 4'd3, 4'd11};
      7'd21: e = '{11'd1286, 4'd2, 4'd7};
      7'd22: e = '{11'd1300, 4'd3, 4'd10};
      7'd23: e = '{11'd1308, 4'd4, 4'd13};
      7'd24: e = '{11'd1333, 4'd1, 4'd3};
      7'd25: e = '{11'd1357, 4'd5, 4'd14};
      7'd26: e = '{11'd1364, 4'd4, 4'd11};
      7'd27: e = '{11'd1375, 4'd3, 4'd8};
      7'd28: e = '{11'd1385, 4'd5, 4'd13};
      7'd29: e = '{11'd1400, 4'd2, 4'd5};
      7'd30: e = '{11'd1417, 4'd5, 4'd12};
      7'd31: e = '{11'd1429, 4'd3, 4'd7};
      7'd32: e = '{11'd1444, 4'd4, 4'd9};
      7'd33: e = '{11'd1455, 4'd5, 4'd11};
      7'd34: e = '{11'd1462, 4'd6, 4'd13};
      7'd35: e = '{11'd1467, 4'd7, 4'd15};
      7'd36: e = '{11'd1500, 4'd1, 4'd2};
      7'd37: e = '{11'd1533, 4'd8, 4'd15};
      7'd38: e = '{11'd1538, 4'd7, 4'd13};
      7'd39: e = '{11'd1545, 4'd6, 4'd11};
      7'd40: e = '{11'd1556, 4'd5, 4'd9};
      7'd41: e = '{11'd1571, 4'd4, 4'd7};
      7'd42: e = '{11'd1583, 4'd7, 4'd12};
      7'd43: e = '{11'd1600, 4'd3, 4'd5};
      7'd44: e = '{11'd1615, 4'd8, 4'd13};
      7'd45: e = '{11'd1625, 4'd5, 4'd8};
      7'd46: e = '{11'd1636, 4'd7, 4'd11};
      7'd47: e = '{11'd1643, 4'd9, 4'd14};
      7'd48: e = '{11'd1667, 4'd2, 4'd3};
      7'd49: e = '{11'd1692, 4'd9, 4'd13};
      7'd50: e = '{11'd1700, 4'd7, 4'd10};
      7'd51: e = '{11'd1714, 4'd5, 4'd7};
      7'd52: e = '{11'd1727, 4'd8, 4'd11};
      7'd53: e = '{11'd1733, 4'd11, 4'd15};
      7'd54: e = '{11'd1750, 4'd3, 4'd4};
      7'd55: e = '{11'd1769, 4'd10, 4'd13};
      7'd56: e = '{11'd1778, 4'd7, 4'd9};
      7'd57: e = '{11'd1786, 4'd11, 4'd14};
      7'd58: e = '{11'd1800, 4'd4, 4'd5};
      7'd59: e = '{11'd1818, 4'd9, 4'd11};
      7'd60: e = '{11'd1833, 4'd5, 4'd6};
      7'd61: e = '{11'd1846, 4'd11, 4'd13};
      7'd62: e = '{11'd1857, 4'd6, 4'd7};
      7'd63: e = '{11'd1867, 4'd13, 4'd15};
      7'd64: e = '{11'd1875, 4'd7, 4'd8};
      7'd65: e = '{11'd1889, 4'd8, 4'd9};
      7'd66: e = '{11'd1900, 4'd9, 4'd10};
      7'd67: e = '{11'd1909, 4'd10, 4'd11};
      7'd68: e = '{11'd1917, 4'd11, 4'd12};
      7'd69: e = '{11'd1923, 4'd12, 4'd13};
      7'd70: e = '{11'd1929, 4'd13, 4'd14};
      7'd71: e = '{11'd1933, 4'd14, 4'd15};
      default: e = '{11'd0, 4'd0, 4'd0};
    endcase
    return e;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/fbds_div.sv =====
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module fbds_div #(
  parameter int WIDTH = 43
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [WIDTH-1:0]  num,
  input  wire logic [WIDTH-1:0]  den,
  output fbds_pkg::unit_stat_t   stat,
  output logic      [WIDTH-1:0]  quo,
  output logic      [WIDTH-1:0]  rem
);

  localparam int CW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] rem_r, quo_r, den_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r, done_r;
  logic [WIDTH:0]   sh, diff;
  logic             ge;

  assign sh   = {rem_r, quo_r[WIDTH-1]};
  assign diff = sh - {1'b0, den_r};
  assign ge   = (sh >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(WIDTH);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= ge ? diff[WIDTH-1:0] : sh[WIDTH-1:0];
      quo_r <= {quo_r[WIDTH-2:0], ge};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quo = quo_r;
  assign rem = rem_r;

endmodule

`default_nettype wire

// ===== rtl/core/fbds_frac_scan.sv =====
`default_nettype none

// Nearest-entry scan over the fraction table, one entry per cycle.
// Strict compare keeps the first minimum.
module fbds_frac_scan #(
  parameter int TABLE_SIZE = 72
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [fbds_pkg::FR_W-1:0]     fr,
  output fbds_pkg::unit_stat_t               stat,
  output logic      [fbds_pkg::MV_W-1:0]     mul_val,
  output logic      [fbds_pkg::MV_W-1:0]     add_val
);

  localparam int SCAN_N = (TABLE_SIZE < fbds_pkg::TAB_ENTRIES) ?
                          TABLE_SIZE : fbds_pkg::TAB_ENTRIES;

  logic [fbds_pkg::TAB_IW-1:0] idx_r;
  logic                        busy_r, done_r;
  logic [fbds_pkg::FR_W-1:0]   best_delta_r, delta;
  logic [fbds_pkg::MV_W-1:0]   best_mul_r, best_add_r;
  fbds_pkg::frac_entry_t       ent;
  logic                        take;

  assign ent   = fbds_pkg::frac_entry(idx_r);
  assign delta = (ent.milli > fr) ? (ent.milli - fr) : (fr - ent.milli);
  assign take  = (idx_r == '0) || (delta < best_delta_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        idx_r  <= '0;
      end else if (busy_r) begin
        if (idx_r == fbds_pkg::TAB_IW'(SCAN_N - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          idx_r <= idx_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r && take) begin
      best_delta_r <= delta;
      best_mul_r   <= ent.mul;
      best_add_r   <= ent.add;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign mul_val   = best_mul_r;
  assign add_val   = best_add_r;

endmodule

`default_nettype wire

// ===== rtl/core/fractional_baud_divisor_search.sv =====
// Channel   Dir  Handshake          Payload
// in_       in   in_tvalid/tready   tdata: bps[21:0]; tuser: port[1:0]
// out_      out  out_tvalid/tready  tdata: divisor, mul_val, div_add_val; tuser: port_out, ok
// cfg_      in   cfg_valid/ready    cfg_data: uart_clock_hz[26:0]
//
// One item at a time; in_tready is high only while the sequencer is idle.
// A zero baud rate goes straight to the result; an exact quotient takes one pass
// of the shared divider; otherwise that pass is followed by two passes per try
// and, once the fraction lands in the band, a scan over the full table.
// Reset (rst_n low, synchronous) clears control and loads uart_clock_hz = 25000000.
// A finished result holds in the output register while out_tready is low; a new
// item is still taken meanwhile, and the sequencer waits at the end if needed.
`default_nettype none

`include "fractional_baud_divisor_search_assert.svh"

module fractional_baud_divisor_search #(
  parameter int MAX_TRIES           = 16,
  parameter int FRACTION_TABLE_SIZE = 72
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input items
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // [21:0] bps, [23:22] zero
  input  wire logic [1:0]  in_tuser,   // [1:0] port
  // result items
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [15:0] divisor, [19:16] mul_val, [23:20] div_add_val
  output logic [2:0]       out_tuser,  // [1:0] port_out, [2] ok
  // configuration
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [26:0] cfg_data    // [26:0] uart_clock_hz
);

  localparam int TRY_W  = $clog2(MAX_TRIES + 1);
  localparam int DIV_W  = fbds_pkg::DIV_W;
  localparam int FR_W   = fbds_pkg::FR_W;
  localparam int MV_W   = fbds_pkg::MV_W;
  localparam int EST_W  = fbds_pkg::EST_W;
  localparam int PROD_W = fbds_pkg::PROD_W;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_XDIV  = 11'b00000000010,  // clk / (16*bps)
    S_XWAIT = 11'b00000000100,
    S_MUL1  = 11'b00000001000,  // base * trial
    S_D1    = 11'b00000010000,  // divisor estimate
    S_D1W   = 11'b00000100000,
    S_MUL2  = 11'b00001000000,  // base * est
    S_D2    = 11'b00010000000,  // real fraction, rounded
    S_D2W   = 11'b00100000000,
    S_SCAN  = 11'b01000000000,
    S_EMIT  = 11'b10000000000
  } state_t;

  // ---------------- registers ----------------
  state_t                          state_r, state_nxt;
  logic [fbds_pkg::CLK_W-1:0]      clk_hz_r;
  logic [fbds_pkg::PORT_W-1:0]     port_r, port_nxt;
  logic [fbds_pkg::BASE_W-1:0]     base_r, base_nxt;
  logic [fbds_pkg::C1K_W-1:0]      c1k_r, c1k_nxt;
  logic [FR_W-1:0]                 trial_r, trial_nxt;
  logic [TRY_W-1:0]                tries_r, tries_nxt;
  logic [EST_W-1:0]                est_r, est_nxt;
  logic [PROD_W-1:0]               mprod_r, mprod_nxt;
  logic [FR_W-1:0]                 fr_r, fr_nxt;
  logic                            res_ok_r, res_ok_nxt;
  logic [EST_W-1:0]                res_div_r, res_div_nxt;
  logic [MV_W-1:0]                 res_mul_r, res_mul_nxt;
  logic [MV_W-1:0]                 res_add_r, res_add_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [fbds_pkg::PORT_W-1:0]     out_port_r, out_port_nxt;
  logic                            out_ok_r, out_ok_nxt;
  logic [EST_W-1:0]                out_div_r, out_div_nxt;
  logic [MV_W-1:0]                 out_mul_r, out_mul_nxt;
  logic [MV_W-1:0]                 out_add_r, out_add_nxt;

  // ---------------- shared units ----------------
  logic                  div_start;
  logic [DIV_W-1:0]      div_num, div_den, div_quo, div_rem;
  fbds_pkg::unit_stat_t  div_stat;
  logic                  scan_start;
  fbds_pkg::unit_stat_t  scan_stat;
  logic [MV_W-1:0]       scan_mul, scan_add;

  fbds_div #(.WIDTH(DIV_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .stat  (div_stat),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  fbds_frac_scan #(.TABLE_SIZE(FRACTION_TABLE_SIZE)) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (scan_start),
    .fr      (fr_r),
    .stat    (scan_stat),
    .mul_val (scan_mul),
    .add_val (scan_add)
  );

  // One multiplier, shared by base*trial and base*est.
  logic [EST_W-1:0]  mul_b;
  logic [PROD_W-1:0] mul_p;
  assign mul_b = (state_r == S_MUL1) ? EST_W'(trial_r) : est_r;
  assign mul_p = PROD_W'(base_r) * PROD_W'(mul_b);

  // clk * 1000 as shift-and-subtract: 1024 - 16 - 8.
  logic [fbds_pkg::C1K_W-1:0] clk_ext, clk_x1000;
  assign clk_ext   = fbds_pkg::C1K_W'(clk_hz_r);
  assign clk_x1000 = (clk_ext << 10) - (clk_ext << 4) - (clk_ext << 3);

  // Trial fraction moves.
  logic [FR_W-1:0]  trial_up, trial_dn, trial_mv;
  logic [TRY_W-1:0] tries_inc;
  logic             quo_big, fr_in_band, fr_low_side;
  assign trial_up    = trial_r + fbds_pkg::FR_STEP;
  assign trial_dn    = trial_r - fbds_pkg::FR_STEP;
  assign tries_inc   = tries_r + 1'b1;
  assign quo_big     = (div_quo[DIV_W-1:EST_W] != '0);
  assign fr_in_band  = (div_quo > DIV_W'(fbds_pkg::FR_LOW)) &&
                       (div_quo < DIV_W'(fbds_pkg::FR_HIGH));
  assign fr_low_side = (div_quo <= DIV_W'(fbds_pkg::FR_LOW));
  assign trial_mv    = fr_low_side ? trial_up : trial_dn;

  // Divider operand select.
  always_comb begin
    div_num = '0;
    div_den = '0;
    case (state_r)
      S_XDIV: begin
        div_num = DIV_W'(clk_hz_r);
        div_den = DIV_W'(base_r);
      end
      S_D1: begin
        div_num = DIV_W'(c1k_r);
        div_den = DIV_W'(mprod_r);
      end
      S_D2: begin
        // (clk*2000 + den) / (2*den): round half up
        div_num = DIV_W'({c1k_r, 1'b0}) + DIV_W'(mprod_r);
        div_den = DIV_W'({mprod_r, 1'b0});
      end
      default: begin
        div_num = '0;
        div_den = '0;
      end
    endcase
  end

  assign div_start  = (state_r == S_XDIV) || (state_r == S_D1) || (state_r == S_D2);
  assign scan_start = (state_r == S_D2W) && div_stat.done && fr_in_band;

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt     = state_r;
    port_nxt      = port_r;
    base_nxt      = base_r;
    c1k_nxt       = c1k_r;
    trial_nxt     = trial_r;
    tries_nxt     = tries_r;
    est_nxt       = est_r;
    mprod_nxt     = mprod_r;
    fr_nxt        = fr_r;
    res_ok_nxt    = res_ok_r;
    res_div_nxt   = res_div_r;
    res_mul_nxt   = res_mul_r;
    res_add_nxt   = res_add_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_port_nxt  = out_port_r;
    out_ok_nxt    = out_ok_r;
    out_div_nxt   = out_div_r;
    out_mul_nxt   = out_mul_r;
    out_add_nxt   = out_add_r;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          port_nxt    = in_tuser;
          base_nxt    = {in_tdata[fbds_pkg::BPS_W-1:0], 4'b0000};
          c1k_nxt     = clk_x1000;
          res_ok_nxt  = 1'b0;
          res_div_nxt = '0;
          res_mul_nxt = '0;
          res_add_nxt = '0;
          // zero baud rate fails at once
          state_nxt   = (in_tdata[fbds_pkg::BPS_W-1:0] == '0) ? S_EMIT : S_XDIV;
        end
      end
      S_XDIV: state_nxt = S_XWAIT;
      S_XWAIT: begin
        if (div_stat.done) begin
          if (div_rem == '0) begin
            // exact quotient: fraction off
            if (div_quo != '0 && !quo_big) begin
              res_ok_nxt  = 1'b1;
              res_div_nxt = div_quo[EST_W-1:0];
              res_mul_nxt = fbds_pkg::FDR_OFF_MUL;
              res_add_nxt = '0;
            end
            state_nxt = S_EMIT;
          end else begin
            trial_nxt = fbds_pkg::FR_START;
            tries_nxt = '0;
            state_nxt = S_MUL1;
          end
        end
      end
      S_MUL1: begin
        mprod_nxt = mul_p;
        state_nxt = S_D1;
      end
      S_D1: state_nxt = S_D1W;
      S_D1W: begin
        if (div_stat.done) begin
          if (div_quo == '0 || quo_big) begin
            state_nxt = S_EMIT;
          end else begin
            est_nxt   = div_quo[EST_W-1:0];
            state_nxt = S_MUL2;
          end
        end
      end
      S_MUL2: begin
        mprod_nxt = mul_p;
        state_nxt = S_D2;
      end
      S_D2: state_nxt = S_D2W;
      S_D2W: begin
        if (div_stat.done) begin
          if (fr_in_band) begin
            fr_nxt    = div_quo[FR_W-1:0];
            state_nxt = S_SCAN;
          end else begin
            trial_nxt = trial_mv;
            tries_nxt = tries_inc;
            // band left, or out of tries
            if (trial_mv < fbds_pkg::FR_LOW || trial_mv > fbds_pkg::FR_HIGH ||
                tries_inc == TRY_W'(MAX_TRIES)) begin
              state_nxt = S_EMIT;
            end else begin
              state_nxt = S_MUL1;
            end
          end
        end
      end
      S_SCAN: begin
        if (scan_stat.done) begin
          res_ok_nxt  = 1'b1;
          res_div_nxt = est_r;
          res_mul_nxt = scan_mul;
          res_add_nxt = scan_add;
          state_nxt   = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_port_nxt  = port_r;
          out_ok_nxt    = res_ok_r;
          out_div_nxt   = res_div_r;
          out_mul_nxt   = res_mul_r;
          out_add_nxt   = res_add_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      clk_hz_r    <= fbds_pkg::CLK_RESET;
      tries_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      tries_r     <= tries_nxt;
      if (cfg_valid) begin
        clk_hz_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    port_r     <= port_nxt;
    base_r     <= base_nxt;
    c1k_r      <= c1k_nxt;
    trial_r    <= trial_nxt;
    est_r      <= est_nxt;
    mprod_r    <= mprod_nxt;
    fr_r       <= fr_nxt;
    res_ok_r   <= res_ok_nxt;
    res_div_r  <= res_div_nxt;
    res_mul_r  <= res_mul_nxt;
    res_add_r  <= res_add_nxt;
    out_port_r <= out_port_nxt;
    out_ok_r   <= out_ok_nxt;
    out_div_r  <= out_div_nxt;
    out_mul_r  <= out_mul_nxt;
    out_add_r  <= out_add_nxt;
  end

  // ---------------- ports ----------------
  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_add_r, out_mul_r, out_div_r};
  assign out_tuser  = {out_ok_r, out_port_r};

  // ---------------- assertions ----------------
  // a failure result carries no setting
  `FBDS_ASSERT_IMP(a_fail_zero, out_tvalid && !out_tuser[2], out_tdata == 24'd0, "failure result not zero")
  // a good setting has a nonzero divisor and DIVADDVAL below MULVAL
  `FBDS_ASSERT_IMP(a_ok_sane, out_tvalid && out_tuser[2], (out_tdata[15:0] != 16'd0) && (out_tdata[23:20] < out_tdata[19:16]), "bad setting")
  // the divider is never restarted mid-division or while the scan runs
  `FBDS_ASSERT_IMP(a_div_free, div_start, !div_stat.busy && !scan_stat.busy, "unit restarted while busy")
  // an accepted item makes the block busy
  `FBDS_ASSERT_NXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "ready after accept")

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;

  localparam int CLK_W  = fbds_pkg::CLK_W;
  localparam int BPS_W  = fbds_pkg::BPS_W;
  localparam int PORT_W = fbds_pkg::PORT_W;

  // Timing and run length. The worst item is a search that walks every try and
  // then scans the fraction list; the limit allows that for every item plus the
  // longest sender gaps and receiver holds, several times over.
  localparam int CYCLE_LIMIT       = 8_000_000;
  localparam int SETTLE_CYCLES     = 200;
  localparam int TRY_LIMIT         = 16;
  localparam int RANDOM_PHASES     = 5;
  localparam int ITEMS_PER_PHASE   = 130;
  localparam logic [BPS_W-1:0] BPS_ALL_ONES = '1;

  // Receiver behavior, changed at random.
  typedef enum int {RX_STEADY, RX_CHOPPY, RX_HOLDS} rx_mode_t;

  // One expected divisor setting, with the request that caused it for reports.
  typedef struct {
    logic [PORT_W-1:0] port;
    logic              ok;
    logic [15:0]       divisor;
    logic [3:0]        mul_val;
    logic [3:0]        div_add_val;
    logic [BPS_W-1:0]  bps;
  } baud_setting_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [26:0] cfg_data = '0;

  // Testbench copy of the clock register; follows every accepted write.
  logic [CLK_W-1:0] uart_clk_hz = fbds_pkg::CLK_RESET;

  baud_setting_t pending_settings[$];
  baud_setting_t oldest_setting;

  int unsigned errors         = 0;
  int unsigned requests_sent  = 0;
  int unsigned results_seen   = 0;
  int unsigned settings_found = 0;
  int unsigned clock_settings = 1;   // reset value counts as the first
  int unsigned burst_left     = 0;

  rx_mode_t    ready_mode       = RX_STEADY;
  int unsigned ready_phase_left = 0;
  int unsigned hold_left        = 0;

  always #10 clk = ~clk;

  fractional_baud_divisor_search #(
    .MAX_TRIES           (TRY_LIMIT),
    .FRACTION_TABLE_SIZE (fbds_pkg::TAB_ENTRIES)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [21:0] bps, [23:22] zero
    .in_tuser   (in_tuser),    // [1:0] port
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [15:0] divisor, [19:16] mul_val, [23:20] div_add_val
    .out_tuser  (out_tuser),   // [1:0] port_out, [2] ok
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)     // [26:0] uart_clock_hz
  );

  // Divisor search in thousandths, 64-bit throughout.
  // Exact division by 16*bps wins outright with the fraction off. Otherwise a
  // trial fraction starting at 1.5 gives the divisor, the real fraction is
  // recomputed with half-up rounding, and a value strictly inside 1.1..1.9 is
  // snapped to the closest 1 + a/m with m up to 15 (the lower value on a tie,
  // which is the earlier entry of the ascending list). Outside the band the
  // trial steps by 0.1 toward it, giving up when it leaves 1.1..1.9 or the
  // tries run out.
  function automatic baud_setting_t predict_setting(input logic [CLK_W-1:0] hz,
                                                    input logic [PORT_W-1:0] port,
                                                    input logic [BPS_W-1:0] bps);
    baud_setting_t    r;
    longint unsigned  clk64, base, trial, est, den, fr;
    longint unsigned  milli, gap_to, best_gap, best_milli;
    int unsigned      tries, a, m, g, h, t, best_a, best_m;
    r.port        = port;
    r.bps         = bps;
    r.ok          = 1'b0;
    r.divisor     = '0;
    r.mul_val     = '0;
    r.div_add_val = '0;
    clk64 = hz;
    base  = bps;
    base  = base * 16;
    if (bps == 0) return r;
    if (clk64 % base == 0) begin
      est = clk64 / base;
      if (est != 0 && est <= 65535) begin
        r.ok          = 1'b1;
        r.divisor     = est[15:0];
        r.mul_val     = fbds_pkg::FDR_OFF_MUL;
        r.div_add_val = '0;
      end
      return r;
    end
    trial = fbds_pkg::FR_START;
    for (tries = 0; tries < TRY_LIMIT; tries++) begin
      est = (clk64 * 1000) / (base * trial);
      if (est == 0 || est > 65535) return r;
      den = base * est;
      fr  = (clk64 * 2000 + den) / (den * 2);
      if (fr > fbds_pkg::FR_LOW && fr < fbds_pkg::FR_HIGH) begin
        best_gap   = '1;
        best_milli = '1;
        best_a     = 0;
        best_m     = 1;
        for (m = 1; m <= 15; m++) begin
          for (a = 0; a < m; a++) begin
            // only reduced fractions; gcd(0, m) = m leaves just 0/1
            g = a;
            h = m;
            while (g != 0) begin
              t = h % g;
              h = g;
              g = t;
            end
            if (h == 1) begin
              milli  = 1000 + (2000 * a + m) / (2 * m);
              gap_to = (milli > fr) ? milli - fr : fr - milli;
              if (gap_to < best_gap || (gap_to == best_gap && milli < best_milli)) begin
                best_gap   = gap_to;
                best_milli = milli;
                best_a     = a;
                best_m     = m;
              end
            end
          end
        end
        r.ok          = 1'b1;
        r.divisor     = est[15:0];
        r.mul_val     = best_m[3:0];
        r.div_add_val = best_a[3:0];
        return r;
      end
      if (fr <= fbds_pkg::FR_LOW) trial = trial + fbds_pkg::FR_STEP;
      else                        trial = trial - fbds_pkg::FR_STEP;
      if (trial < fbds_pkg::FR_LOW || trial > fbds_pkg::FR_HIGH) return r;
    end
    return r;
  endfunction

  // Random baud rate for a given clock. Most requests land where the divisor
  // fits, so the search really runs; the rest are exact quotients, raw noise
  // across all 22 bits, and the field edges.
  function automatic logic [BPS_W-1:0] pick_baud_rate(input logic [CLK_W-1:0] hz);
    longint unsigned q, d, f, v;
    int unsigned     kind, k;
    kind = $urandom_range(0, 19);
    if (kind == 0) begin
      case ($urandom_range(0, 3))
        0:       return '0;
        1:       return 22'd1;
        2:       return BPS_ALL_ONES;
        default: return 22'd4000000;
      endcase
    end
    if (kind <= 3) return BPS_W'($urandom);
    if (kind <= 5) begin
      k = $urandom_range(0, 21);
      return BPS_W'((32'd1 << k) | ($urandom & ((32'd1 << k) - 1)));
    end
    if (kind <= 8 && hz % 16 == 0) begin
      q = hz / 16;
      d = $urandom_range(1, 64);
      if (q % d == 0 && q / d <= BPS_ALL_ONES) return BPS_W'(q / d);
    end
    // aim at divisor d with a fraction somewhere around 1.0..2.0
    k = $urandom_range(0, 15);
    d = (64'd1 << k) | ($urandom & ((32'd1 << k) - 1));
    f = $urandom_range(1000, 2000);
    v = (64'(hz) * 1000) / (16 * d * f);
    if (v == 0) v = 1;
    if (v > BPS_ALL_ONES) v = BPS_ALL_ONES;
    return BPS_W'(v);
  endfunction

  // Sends one request, records its expected setting on acceptance, then
  // maybe opens a gap. Entered and left at a falling edge; valid is only
  // lowered when a gap starts, so back-to-back items keep it high.
  task automatic send_request(input logic [PORT_W-1:0] port, input logic [BPS_W-1:0] bps);
    int unsigned gap;
    in_tuser  = port;
    in_tdata  = {2'b00, bps};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    pending_settings.push_back(predict_setting(uart_clk_hz, port, bps));
    requests_sent++;
    @(negedge clk);
    if (burst_left == 0) begin
      in_tvalid = 1'b0;
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 400) : $urandom_range(1, 20);
      repeat (gap) @(negedge clk);
      // now and then a long run with no idling at all
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 6);
    end else begin
      burst_left--;
    end
  endtask

  // Block idle: every expected setting back and a little slack after it.
  task automatic wait_until_drained();
    in_tvalid = 1'b0;
    while (pending_settings.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_uart_clock(input logic [CLK_W-1:0] hz);
    cfg_data  = hz;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    uart_clk_hz = hz;
    clock_settings++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Reset clock of 25 MHz, never written: exact quotients, the zero rate,
  // quotient too large, estimate zero and ordinary searches.
  task automatic test_reset_clock();
    send_request(2'd0, 22'd15625);      // exactly 100
    send_request(2'd1, 22'd0);          // zero rate
    send_request(2'd2, 22'd1);          // exact but far above 16 bits
    send_request(2'd3, BPS_ALL_ONES);   // estimate rounds to zero
    send_request(2'd0, 22'd1562500);    // exact quotient of one
    send_request(2'd1, 22'd115200);
    send_request(2'd2, 22'd9600);
    send_request(2'd3, 22'd921600);
    wait_until_drained();
  endtask

  // Clock register at 1 Hz and at 100 MHz.
  task automatic test_clock_extremes();
    write_uart_clock(27'd1);
    send_request(2'd0, 22'd1);          // estimate zero at a 1 Hz clock
    send_request(2'd3, 22'd0);
    wait_until_drained();
    write_uart_clock(27'd100000000);
    send_request(2'd2, 22'd47);         // estimate above 16 bits
    send_request(2'd3, 22'd50);         // exact quotient above 16 bits
    send_request(2'd1, 22'd3125000);    // exact quotient of two
    send_request(2'd2, 22'd4000000);    // divisor one with a fraction
    send_request(2'd3, 22'd115200);
    send_request(2'd0, BPS_ALL_ONES);
    wait_until_drained();
  endtask

  // Common crystal rates against standard baud rates.
  task automatic test_standard_rates();
    write_uart_clock(27'd14745600);
    send_request(2'd0, 22'd9600);
    send_request(2'd1, 22'd115200);
    send_request(2'd2, 22'd100000);
    wait_until_drained();
    write_uart_clock(27'd12000000);
    send_request(2'd3, 22'd9600);
    send_request(2'd0, 22'd57600);
    send_request(2'd1, 22'd250000);
    wait_until_drained();
  endtask

  // Random traffic, one clock setting per phase; the last phase sits at the top.
  task automatic test_random_traffic();
    logic [CLK_W-1:0] hz;
    int unsigned      p, n;
    for (p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0:       hz = fbds_pkg::CLK_RESET;
        1:       hz = CLK_W'($urandom_range(1, 100000000));
        2:       hz = CLK_W'($urandom_range(1, 2000000));
        3:       hz = CLK_W'(16 * $urandom_range(1, 6250000));
        default: hz = 27'd100000000;
      endcase
      write_uart_clock(hz);
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_request(PORT_W'($urandom_range(0, 3)), pick_baud_rate(hz));
      end
      wait_until_drained();
    end
  endtask

  // Receiver: steady, choppy or with long holds, switching every so often.
  always @(negedge clk) begin
    if (ready_phase_left == 0) begin
      ready_mode       = rx_mode_t'($urandom_range(0, 2));
      ready_phase_left = $urandom_range(20, 400);
    end
    ready_phase_left--;
    case (ready_mode)
      RX_STEADY: out_tready = 1'b1;
      RX_CHOPPY: out_tready = ($urandom_range(0, 3) != 0);
      default: begin
        if (hold_left != 0) begin
          hold_left--;
          out_tready = 1'b0;
        end else if ($urandom_range(0, 15) == 0) begin
          hold_left  = $urandom_range(1, 60);
          out_tready = 1'b0;
        end else begin
          out_tready = 1'b1;
        end
      end
    endcase
  end

  // Result checker: each accepted result against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (pending_settings.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: tdata %h tuser %h", out_tdata, out_tuser);
      end else begin
        oldest_setting = pending_settings.pop_front();
        if (oldest_setting.ok) settings_found++;
        if (out_tuser[1:0]   !== oldest_setting.port    ||
            out_tuser[2]     !== oldest_setting.ok      ||
            out_tdata[15:0]  !== oldest_setting.divisor ||
            out_tdata[19:16] !== oldest_setting.mul_val ||
            out_tdata[23:20] !== oldest_setting.div_add_val) begin
          errors++;
          if (errors <= 10)
            $display({"mismatch clk %0d bps %0d: expected port %0d ok %0d div %0d mul %0d ",
                      "add %0d, got port %0d ok %0d div %0d mul %0d add %0d"},
                     uart_clk_hz, oldest_setting.bps, oldest_setting.port, oldest_setting.ok,
                     oldest_setting.divisor, oldest_setting.mul_val,
                     oldest_setting.div_add_val, out_tuser[1:0], out_tuser[2],
                     out_tdata[15:0], out_tdata[19:16], out_tdata[23:20]);
        end
      end
    end
  end

  // Watchdog.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d results outstanding",
             CYCLE_LIMIT, pending_settings.size());
    $display("status: fail");
    $finish;
  end

  initial begin
    // synchronous reset held, then released at a falling edge
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_clock();
    test_clock_extremes();
    test_standard_rates();
    test_random_traffic();

    wait_until_drained();
    // anything still queued never came back
    errors = errors + pending_settings.size();

    $display("covered %0d requests over %0d clock settings, all four ports", requests_sent,
             clock_settings);
    $display("%0d results checked: %0d divisor settings found, %0d rejected, %0d errors",
             results_seen, settings_found, results_seen - settings_found, errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/fbds_pkg.sv
rtl/core/fbds_div.sv
rtl/core/fbds_frac_scan.sv
rtl/core/fractional_baud_divisor_search.sv
tb/sv/tb.sv
